// File: rtl/nlp_pkg.sv
package nlp_pkg;

   // default limit on digits after the hex prefix
   localparam int MAX_HEX_DIGITS_DEFAULT = 8;

   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;

   // characters the parser looks for
   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // parse mode, one-hot
   typedef enum logic [4:0] {
      MODE_START = 5'b00001,
      MODE_ZERO  = 5'b00010,
      MODE_DEC   = 5'b00100,
      MODE_HEX   = 5'b01000,
      MODE_BAD   = 5'b10000
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [VALUE_WIDTH-1:0]   acc;
      logic                     negative;
      logic [COUNT_WIDTH-1:0]   count;
   } parse_state_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]   value;
      logic [COUNT_WIDTH-1:0]   char_count;
      logic                     status;
   } result_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      mode:     MODE_START,
      acc:      '0,
      negative: 1'b0,
      count:    '0
   };

   // hex digit value, bit 4 set when the character is not a hex digit
   function automatic logic [4:0] hex_nibble(input logic [CHAR_WIDTH-1:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b0, 4'(c - CHAR_ZERO)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         r = {1'b0, 4'(c - CHAR_LOWER_A + 8'd10)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r = {1'b0, 4'(c - CHAR_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

endpackage

// File: rtl/nlp_step.sv
module nlp_step #(
   parameter int MAX_HEX_DIGITS = nlp_pkg::MAX_HEX_DIGITS_DEFAULT
) (
   input  logic [nlp_pkg::CHAR_WIDTH-1:0] char_code,
   input  nlp_pkg::parse_state_type       cur,
   output nlp_pkg::parse_state_type       nxt,
   output nlp_pkg::result_type            result
);

   logic                               is_term;
   logic                               is_digit;
   logic [3:0]                         digit;
   logic [4:0]                         nibble;
   logic [nlp_pkg::VALUE_WIDTH-1:0]    acc_dec;
   logic [nlp_pkg::COUNT_WIDTH-1:0]    count_sat;
   logic                               hex_full;

   // character classes
   assign is_term  = (char_code == nlp_pkg::CHAR_NUL);
   assign is_digit = (char_code >= nlp_pkg::CHAR_ZERO) && (char_code <= nlp_pkg::CHAR_NINE);
   assign digit    = 4'(char_code - nlp_pkg::CHAR_ZERO);
   assign nibble   = nlp_pkg::hex_nibble(char_code);

   // decimal step: acc * 10 + digit, wrapping
   assign acc_dec   = (cur.acc << 3) + (cur.acc << 1) + nlp_pkg::VALUE_WIDTH'(digit);
   assign count_sat = (cur.count == nlp_pkg::COUNT_MAX) ? cur.count : cur.count + 1'b1;
   assign hex_full  = (cur.count >= nlp_pkg::COUNT_WIDTH'(MAX_HEX_DIGITS));

   // result for a terminator
   always_comb begin
      if (cur.mode == nlp_pkg::MODE_BAD) begin
         result = '{value: '0, char_count: '0, status: 1'b1};
      end else begin
         result.value      = cur.negative ? (nlp_pkg::VALUE_WIDTH'(0) - cur.acc) : cur.acc;
         result.char_count = cur.count;
         result.status     = 1'b0;
      end
   end

   // next parse state
   always_comb begin
      nxt = cur;
      if (is_term) begin
         nxt = nlp_pkg::PARSE_STATE_RESET;
      end else begin
         unique case (cur.mode)
            nlp_pkg::MODE_START: begin
               if (char_code == nlp_pkg::CHAR_MINUS) begin
                  nxt.negative = 1'b1;
                  nxt.count    = nlp_pkg::COUNT_WIDTH'(1);
                  nxt.mode     = nlp_pkg::MODE_DEC;
               end else if (is_digit) begin
                  nxt.acc   = acc_dec;
                  nxt.count = count_sat;
                  nxt.mode  = (char_code == nlp_pkg::CHAR_ZERO) ? nlp_pkg::MODE_ZERO
                                                                  : nlp_pkg::MODE_DEC;
               end else begin
                  nxt.mode = nlp_pkg::MODE_BAD;
               end
            end
            nlp_pkg::MODE_ZERO: begin
               if (char_code == nlp_pkg::CHAR_LOWER_X || char_code == nlp_pkg::CHAR_UPPER_X) begin
                  nxt.acc   = '0;
                  nxt.count = '0;
                  nxt.mode  = nlp_pkg::MODE_HEX;
               end else if (is_digit) begin
                  nxt.acc   = acc_dec;
                  nxt.count = count_sat;
                  nxt.mode  = nlp_pkg::MODE_DEC;
               end else begin
                  nxt.mode = nlp_pkg::MODE_BAD;
               end
            end
            nlp_pkg::MODE_DEC: begin
               if (is_digit) begin
                  nxt.acc   = acc_dec;
                  nxt.count = count_sat;
               end else begin
                  nxt.mode = nlp_pkg::MODE_BAD;
               end
            end
            nlp_pkg::MODE_HEX: begin
               if (nibble[4] || hex_full) begin
                  nxt.mode = nlp_pkg::MODE_BAD;
               end else begin
                  nxt.acc   = {cur.acc[nlp_pkg::VALUE_WIDTH-5:0], nibble[3:0]};
                  nxt.count = cur.count + 1'b1;
               end
            end
            default: begin
               nxt.mode = nlp_pkg::MODE_BAD;
            end
         endcase
      end
   end

endmodule

// File: rtl/number_literal_parser.sv
// Parses a zero-terminated ASCII number literal into a 32-bit value.
// Input channel req_*: one character per beat in req_tdata[7:0]; a zero
// character ends the string. "0x"/"0X" selects hex (up to MAX_HEX_DIGITS
// digits), otherwise decimal with an optional leading minus.
// Result channel rsp_*: one beat per terminator, carrying value, char_count
// in rsp_tdata and the status flag (1 = invalid string) in rsp_tuser.
// Throughput: one character per cycle while no terminator waits on a full
// result register; the parse step (shift-or for hex, multiply-by-ten-add for
// decimal) is combinational between the input and parse state registers.
// The terminator beat passes the input register, then the result register,
// before its result beat is presented.
// Reset clears the valid flags of the input and result registers and returns
// the parser to the start of a string.
// When the receiver stalls, the result register holds its beat; characters
// keep being taken until a second terminator reaches the input register,
// which then waits, and req_tready drops until the result beat is taken.
module number_literal_parser #(
   parameter int MAX_HEX_DIGITS = nlp_pkg::MAX_HEX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] value, [47:32] char_count
   output logic [0:0]  rsp_tuser    // [0] status
);

   logic                            in_valid_ff, in_valid_in;
   logic [nlp_pkg::CHAR_WIDTH-1:0]  in_char_ff;
   nlp_pkg::parse_state_type        state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   nlp_pkg::result_type             rsp_data_ff;
   nlp_pkg::result_type             step_result;
   logic                            out_free;
   logic                            in_term;
   logic                            in_fire;

   // parse step
   nlp_step #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_step (
      .char_code(in_char_ff),
      .cur      (state_ff),
      .nxt      (state_in),
      .result   (step_result)
   );

   // flow control: only a terminator needs the result register
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign in_term     = (in_char_ff == nlp_pkg::CHAR_NUL);
   assign in_fire     = in_valid_ff && (!in_term || out_free);
   assign req_tready  = !in_valid_ff || in_fire;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nlp_pkg::PARSE_STATE_RESET;
      end else if (in_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      if (in_fire && in_term) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && in_term) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.char_count, rsp_data_ff.value};
   assign rsp_tuser  = rsp_data_ff.status;

   // a terminator leaves the parser at the start of a fresh string
   assert property (@(posedge clock) disable iff (reset)
      in_fire && in_term |=> state_ff.mode == nlp_pkg::MODE_START && state_ff.acc == '0
                             && state_ff.count == '0 && !state_ff.negative)
      else $error("parser not cleared after terminator");

   // hex digit count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == nlp_pkg::MODE_HEX |->
         state_ff.count <= nlp_pkg::COUNT_WIDTH'(MAX_HEX_DIGITS))
      else $error("hex digit count beyond limit");

   // an invalid result carries zero value and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid result with nonzero payload");

   // input stalls only for a terminator blocked by a full result register
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && in_term && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without cause");

   // a result beat appears only after a terminator was processed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_fire && in_term))
      else $error("result beat without terminator");

endmodule

// File: tb/number_literal_checker.sv
module number_literal_checker
   import nlp_pkg::*;
#(
   parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [31:0] value, [47:32] char_count
   input  logic [0:0]  rsp_tuser,   // [0] status
   output int          fail_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow parse state
   mode_type                 mode;
   logic [VALUE_WIDTH-1:0]   acc;
   logic                     negative;
   logic [COUNT_WIDTH-1:0]   count;

   // results owed by the parser, oldest first
   result_type               owed_results[$];
   int                       mismatches = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic bit is_decimal(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   task automatic clear_parse();
      mode     = MODE_START;
      acc      = '0;
      negative = 1'b0;
      count    = '0;
   endtask

   // multiply-by-ten-add, length saturates
   task automatic add_decimal(input logic [7:0] c);
      acc = acc * 32'd10 + 32'(c - CHAR_ZERO);
      if (count != COUNT_MAX) begin
         count = count + 1'b1;
      end
   endtask

   // advance the parse by one character, owe a result on the terminator
   task automatic take_char(input logic [7:0] c);
      result_type r;
      int         nibble;
      if (c == CHAR_NUL) begin
         if (mode == MODE_BAD) begin
            r.value      = '0;
            r.char_count = '0;
            r.status     = 1'b1;
         end else begin
            r.value      = negative ? (32'd0 - acc) : acc;
            r.char_count = count;
            r.status     = 1'b0;
         end
         owed_results.push_back(r);
         clear_parse();
      end else begin
         case (mode)
            MODE_START: begin
               if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  count    = 16'd1;
                  mode     = MODE_DEC;
               end else if (is_decimal(c)) begin
                  add_decimal(c);
                  mode = (c == CHAR_ZERO) ? MODE_ZERO : MODE_DEC;
               end else begin
                  mode = MODE_BAD;
               end
            end
            MODE_ZERO: begin
               if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                  acc   = '0;
                  count = '0;
                  mode  = MODE_HEX;
               end else if (is_decimal(c)) begin
                  add_decimal(c);
                  mode = MODE_DEC;
               end else begin
                  mode = MODE_BAD;
               end
            end
            MODE_DEC: begin
               if (is_decimal(c)) begin
                  add_decimal(c);
               end else begin
                  mode = MODE_BAD;
               end
            end
            MODE_HEX: begin
               // decode digit, -1 when not a hex digit
               if (is_decimal(c)) begin
                  nibble = c - CHAR_ZERO;
               end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
                  nibble = c - CHAR_LOWER_A + 10;
               end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
                  nibble = c - CHAR_UPPER_A + 10;
               end else begin
                  nibble = -1;
               end
               if (nibble < 0 || count >= MAX_HEX_DIGITS) begin
                  mode = MODE_BAD;
               end else begin
                  acc   = {acc[VALUE_WIDTH-5:0], 4'(nibble)};
                  count = count + 1'b1;
               end
            end
            default: begin
               mode = MODE_BAD;
            end
         endcase
      end
   endtask

   // compare result beats against the oldest owed result, then predict
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         clear_parse();
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value      = rsp_tdata[31:0];
            got.char_count = rsp_tdata[47:32];
            got.status     = rsp_tuser[0];
            if (owed_results.size() == 0) begin
               report_mismatch("result beat with none owed", got.value, 32'd0);
            end else begin
               want = owed_results.pop_front();
               if (got.value != want.value) begin
                  report_mismatch("value", got.value, want.value);
               end
               if (got.char_count != want.char_count) begin
                  report_mismatch("char_count", 32'(got.char_count),
                                  32'(want.char_count));
               end
               if (got.status != want.status) begin
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_char(req_tdata);
         end
      end
      pending_results <= owed_results.size();
      fail_count      <= mismatches;
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nlp_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_CHARS    = 125;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // [31:0] value, [47:32] char_count
   logic [0:0]  rsp_tuser;          // [0] status

   int          idle_pct     = 0;
   int          stall_pct    = 0;
   logic        hold_want    = 1'b0;
   logic        hold_taken   = 1'b0;
   int          hold_left    = 0;
   int          chars_sent   = 0;
   int          quiet_cycles = 0;
   int          fail_count;
   int          pending_results;

   number_literal_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   number_literal_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // receiver: one long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_want && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [7:0] random_digit();
      return 8'(CHAR_ZERO + $urandom_range(9));
   endfunction

   function automatic logic [7:0] random_hex_char();
      int d;
      d = $urandom_range(15);
      if (d < 10) begin
         return 8'(CHAR_ZERO + d);
      end
      return 8'(($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + d - 10);
   endfunction

   // one character beat, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
      send_char(CHAR_NUL);
   endtask

   // mostly well-formed literals, some broken ones and some noise
   task automatic send_random_literal();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 35) begin
         // decimal, may wrap past 32 bits
         if ($urandom_range(3) == 0) begin
            send_char(CHAR_MINUS);
         end
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            send_char(random_digit());
         end
      end else if (kind < 70) begin
         // hex, sometimes one digit too many
         send_char(CHAR_ZERO);
         send_char($urandom_range(1) ? CHAR_LOWER_X : CHAR_UPPER_X);
         n = ($urandom_range(2) == 0) ? MAX_HEX_DIGITS_DEFAULT : $urandom_range(0, 9);
         for (int i = 0; i < n; i++) begin
            send_char(random_hex_char());
         end
      end else if (kind < 85) begin
         // good start, then any nonzero byte, then more digits
         if ($urandom_range(1)) begin
            send_char(CHAR_ZERO);
            send_char(CHAR_UPPER_X);
         end
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            send_char(random_digit());
         end
         send_char(8'($urandom_range(1, 255)));
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            send_char(random_hex_char());
         end
      end else begin
         // raw bytes
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            send_char(8'($urandom_range(1, 255)));
         end
      end
      send_char(CHAR_NUL);
   endtask

   // sender goes quiet until every owed result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_phase(input int idle, input int stall);
      int target;
      idle_pct  = idle;
      stall_pct <= stall;
      target    = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
         send_random_literal();
      end
      wait_for_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, lone minus, lone zero, bare prefix, mixed-case hex,
      // negative, misplaced minus, double minus, high byte
      send_text("");
      send_text("-");
      send_text("0");
      send_text("0x");
      send_text("0XaF");
      send_text("-9");
      send_text("7-");
      send_text("--");
      send_char(8'hff);
      send_char(CHAR_NUL);

      // random phases, the first one under a long receiver hold-off
      hold_want <= 1'b1;
      run_phase(0, 0);
      run_phase(79, 0);
      run_phase(0, 79);
      run_phase(12, 12);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
